/* hw/rtl/bor_pkg.sv */
// Package for the box overlap ratio block: field widths, request and result
// structs, and the record that travels down the divider pipeline.
// No dependencies.
package bor_pkg;

    localparam int COORD_BITS    = 16;
    localparam int FRACTION_BITS = 16;

    // Derived widths.
    localparam int PROD_BITS = 2 * COORD_BITS;      // any area
    localparam int DEN_BITS  = PROD_BITS + 1;       // union area may carry
    localparam int QUO_BITS  = FRACTION_BITS + 1;   // ratio, 1.0 included
    localparam int DIV_STEPS = QUO_BITS;            // one quotient bit a stage

    localparam logic [QUO_BITS-1:0] RATIO_ONE = QUO_BITS'(1) << FRACTION_BITS;

    typedef enum logic {
        CMD_UNION   = 1'b0,
        CMD_SMALLER = 1'b1
    } t_cmd;

    typedef struct packed {
        t_cmd                  command;
        logic [COORD_BITS-1:0] first_x;
        logic [COORD_BITS-1:0] first_y;
        logic [COORD_BITS-1:0] first_width;
        logic [COORD_BITS-1:0] first_height;
        logic [COORD_BITS-1:0] second_x;
        logic [COORD_BITS-1:0] second_y;
        logic [COORD_BITS-1:0] second_width;
        logic [COORD_BITS-1:0] second_height;
    } t_req;

    typedef struct packed {
        logic [QUO_BITS-1:0] ratio;
        logic                intersects;
    } t_res;

    // Partial remainder, divisor, quotient so far, the bit shifted in by the
    // next step and the overlap flag.
    typedef struct packed {
        logic [DEN_BITS-1:0] rem;
        logic [DEN_BITS-1:0] den;
        logic [QUO_BITS-1:0] quo;
        logic                feed;
        logic                hit;
    } t_div;

endpackage

/* hw/rtl/box_overlap_ratio.sv */
// Top level of the box overlap ratio block: front end followed by the
// pipelined divider. Depends on bor_pkg, bor_front and bor_div_step.

// Box overlap ratio (intersection over union, or over the smaller box).
// Each request carries two boxes as corner, width and height plus a command;
// the result is the overlap ratio in unsigned fixed point with FRACTION_BITS
// fraction bits, truncated, and a flag that is set when the boxes overlap
// with positive width and height. Boxes that merely touch give a zero ratio.
// The block is a fully pipelined datapath: while results are taken, a new
// request can be accepted in every cycle and one result leaves in every
// cycle, so throughput is one box pair per clock. The pipeline has three
// front-end stages for the span overlap, the area products and the divisor,
// then one restoring division stage for each of the FRACTION_BITS + 1
// quotient bits. Every stage holds its own valid bit and advances whenever
// it is empty or its successor advances, so bubbles close up behind a
// stalled output and requests keep being taken until the whole pipeline is
// full. The last division stage is the output register.
module box_overlap_ratio (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  bor_pkg::t_req i_req,
    output logic          o_res_valid,
    input  logic          i_res_ready,
    output bor_pkg::t_res o_res
);
    import bor_pkg::*;

    // Stage k of the divider takes s_div[k] and presents s_div[k+1]; s_adv[k]
    // tells the producer of s_div[k] that it may move on.
    t_div                 s_div [DIV_STEPS+1];
    logic [DIV_STEPS:0]   s_valid;
    logic [DIV_STEPS:0]   s_adv;

    bor_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_req_valid),
        .o_ready (o_req_ready),
        .i_req   (i_req),
        .o_valid (s_valid[0]),
        .i_ready (s_adv[0]),
        .o_div   (s_div[0])
    );

    // One quotient bit per stage, most significant first. The first stage
    // sees the numerator itself: its upper bits as remainder and its lowest
    // bit as the bit shifted in, which yields the integer bit of the ratio.
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        bor_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (s_valid[k]),
            .o_ready (s_adv[k]),
            .i_div   (s_div[k]),
            .o_valid (s_valid[k+1]),
            .i_ready (s_adv[k+1]),
            .o_div   (s_div[k+1])
        );
    end

    assign s_adv[DIV_STEPS] = i_res_ready;

    // Non-overlapping pairs were fed a zero numerator, so the quotient is
    // already zero for them and no further masking is needed here.
    assign o_res_valid      = s_valid[DIV_STEPS];
    assign o_res.ratio      = s_div[DIV_STEPS].quo;
    assign o_res.intersects = s_div[DIV_STEPS].hit;

    // A result without overlap must carry a zero ratio.
    a_no_hit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && !o_res.intersects |-> o_res.ratio == '0)
        else $error("ratio not zero for boxes that do not overlap");

    // The numerator never exceeds the divisor, so the ratio is at most 1.0.
    a_ratio_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> o_res.ratio <= RATIO_ONE)
        else $error("ratio above one");

    // Overlapping boxes always give the divider a non-zero divisor.
    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_valid[0] && s_div[0].hit |-> s_div[0].den != '0)
        else $error("zero divisor for overlapping boxes");

    // An empty output register can always take a result, so the stage
    // before it must advance.
    a_empty_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_res_valid |-> s_adv[DIV_STEPS-1])
        else $error("last division stage stalled while output is empty");

endmodule

/* hw/rtl/bor_front.sv */
// Front end of the box overlap ratio block: span overlap, the three area
// products and the divisor selection, in three register stages.
// Depends on bor_pkg.
module bor_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  bor_pkg::t_req i_req,
    output logic          o_valid,
    input  logic          i_ready,
    output bor_pkg::t_div o_div
);
    import bor_pkg::*;

    typedef struct packed {
        t_cmd                  cmd;
        logic                  pos_w;
        logic                  pos_h;
        logic [COORD_BITS-1:0] iw;
        logic [COORD_BITS-1:0] ih;
        logic [COORD_BITS-1:0] w1;
        logic [COORD_BITS-1:0] h1;
        logic [COORD_BITS-1:0] w2;
        logic [COORD_BITS-1:0] h2;
    } t_span;

    typedef struct packed {
        t_cmd                 cmd;
        logic                 hit;
        logic [PROD_BITS-1:0] inter;
        logic [PROD_BITS-1:0] area1;
        logic [PROD_BITS-1:0] area2;
    } t_area;

    // Overlap of [a, a+la) and [b, b+lb) is min(end) - max(start).
    function automatic logic [COORD_BITS+1:0] span_diff(
        input logic [COORD_BITS-1:0] a,
        input logic [COORD_BITS-1:0] la,
        input logic [COORD_BITS-1:0] b,
        input logic [COORD_BITS-1:0] lb
    );
        logic [COORD_BITS:0]   end_a;
        logic [COORD_BITS:0]   end_b;
        logic [COORD_BITS:0]   min_end;
        logic [COORD_BITS-1:0] max_start;
        end_a     = {1'b0, a} + {1'b0, la};
        end_b     = {1'b0, b} + {1'b0, lb};
        min_end   = (end_a < end_b) ? end_a : end_b;
        max_start = (a > b) ? a : b;
        return {1'b0, min_end} - {2'b00, max_start};
    endfunction

    logic                  r_v1, r_v2, r_v3;
    logic                  adv1, adv2, adv3;
    t_span                 r_s1, n_s1;
    t_area                 r_s2, n_s2;
    t_div                  r_s3, n_s3;
    logic [COORD_BITS+1:0] dx, dy;
    logic [DEN_BITS-1:0]   uni;
    logic [PROD_BITS-1:0]  smaller;

    assign adv3    = !r_v3 || i_ready;
    assign adv2    = !r_v2 || adv3;
    assign adv1    = !r_v1 || adv2;
    assign o_ready = adv1;
    assign o_valid = r_v3;
    assign o_div   = r_s3;

    // Stage 1: signed overlap length on each axis.
    always_comb begin
        dx = span_diff(i_req.first_x, i_req.first_width,
                       i_req.second_x, i_req.second_width);
        dy = span_diff(i_req.first_y, i_req.first_height,
                       i_req.second_y, i_req.second_height);
        n_s1.cmd   = i_req.command;
        n_s1.pos_w = !dx[COORD_BITS+1] && (dx != '0);
        n_s1.pos_h = !dy[COORD_BITS+1] && (dy != '0);
        // A positive overlap never exceeds the smaller size, so it fits.
        n_s1.iw    = dx[COORD_BITS-1:0];
        n_s1.ih    = dy[COORD_BITS-1:0];
        n_s1.w1    = i_req.first_width;
        n_s1.h1    = i_req.first_height;
        n_s1.w2    = i_req.second_width;
        n_s1.h2    = i_req.second_height;
    end

    // Stage 2: intersection area and both box areas.
    always_comb begin
        n_s2.cmd   = r_s1.cmd;
        n_s2.hit   = r_s1.pos_w && r_s1.pos_h;
        n_s2.inter = {{COORD_BITS{1'b0}}, r_s1.iw} * {{COORD_BITS{1'b0}}, r_s1.ih};
        n_s2.area1 = {{COORD_BITS{1'b0}}, r_s1.w1} * {{COORD_BITS{1'b0}}, r_s1.h1};
        n_s2.area2 = {{COORD_BITS{1'b0}}, r_s1.w2} * {{COORD_BITS{1'b0}}, r_s1.h2};
    end

    // Stage 3: divisor selection. Without overlap the division is fed 0 / 1
    // so that the quotient comes out as zero.
    always_comb begin
        uni     = {1'b0, r_s2.area1} + {1'b0, r_s2.area2} - {1'b0, r_s2.inter};
        smaller = (r_s2.area1 < r_s2.area2) ? r_s2.area1 : r_s2.area2;
        n_s3.quo = '0;
        n_s3.hit = r_s2.hit;
        if (!r_s2.hit) begin
            n_s3.rem  = '0;
            n_s3.feed = 1'b0;
            n_s3.den  = DEN_BITS'(1);
        end else begin
            n_s3.rem  = DEN_BITS'(r_s2.inter >> 1);
            n_s3.feed = r_s2.inter[0];
            case (r_s2.cmd)
                CMD_UNION:   n_s3.den = uni;
                CMD_SMALLER: n_s3.den = {1'b0, smaller};
                default:     n_s3.den = uni;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (adv1) r_v1 <= i_valid;
            if (adv2) r_v2 <= r_v1;
            if (adv3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1) r_s1 <= n_s1;
        if (adv2) r_s2 <= n_s2;
        if (adv3) r_s3 <= n_s3;
    end

endmodule

/* hw/rtl/bor_div_step.sv */
// One restoring division stage of the box overlap ratio block: shifts in a
// bit, compares with the divisor and produces one quotient bit.
// Depends on bor_pkg.
module bor_div_step (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  bor_pkg::t_div i_div,
    output logic          o_valid,
    input  logic          i_ready,
    output bor_pkg::t_div o_div
);
    import bor_pkg::*;

    logic                r_valid;
    t_div                r_div, n_div;
    logic [DEN_BITS:0]   shifted;
    logic [DEN_BITS:0]   diff;
    logic                ge;
    logic                adv;

    assign adv     = !r_valid || i_ready;
    assign o_ready = adv;
    assign o_valid = r_valid;
    assign o_div   = r_div;

    always_comb begin
        shifted    = {i_div.rem, i_div.feed};
        diff       = shifted - {1'b0, i_div.den};
        ge         = (shifted >= {1'b0, i_div.den});
        n_div      = i_div;
        // The remainder stays below the divisor, so it fits either way.
        n_div.rem  = ge ? diff[DEN_BITS-1:0] : shifted[DEN_BITS-1:0];
        n_div.quo  = {i_div.quo[QUO_BITS-2:0], ge};
        n_div.feed = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) r_div <= n_div;
    end

endmodule

/* tb/tb_box_overlap_ratio.sv */
// Testbench for box_overlap_ratio: directed and random box pairs are checked
// against a behavioural predictor of the overlap ratio under random handshake idling.
// Depends on bor_pkg and the box_overlap_ratio RTL.
module tb_box_overlap_ratio;

    timeunit 1ns;
    timeprecision 1ps;

    import bor_pkg::*;

    // The pipeline is FRACTION_BITS + 4 deep, so twice that covers the drain
    // after the last expected result.
    localparam int LATENCY       = FRACTION_BITS + 4;
    localparam int DRAIN_CYCLES  = 2 * LATENCY;
    // The slowest correct run is about 420 requests with the largest gaps on both
    // sides, plus the pipeline fill. That comes to far less than this limit.
    localparam int CYCLE_LIMIT   = 200_000;
    localparam int RANDOM_PAIRS  = 400;
    localparam int MAX_REPORTED  = 10;
    localparam int COORD_MAX     = (1 << COORD_BITS) - 1;

    logic i_clk;
    logic i_rst_n;
    logic i_req_valid;
    logic o_req_ready;
    t_req i_req;
    logic o_res_valid;
    logic i_res_ready;
    t_res o_res;

    // Results predicted for accepted requests and not yet seen at the output.
    t_res expected_ratios[$];
    int   error_count;
    int   cycle_count;
    // While set, the corresponding side runs without gaps.
    bit   calm_requests;
    bit   calm_results;

    box_overlap_ratio u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_res_valid (o_res_valid),
        .i_res_ready (i_res_ready),
        .o_res       (o_res)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Signed overlap of the spans [a, a + la) and [b, b + lb). A value of
    // zero or less means the spans are disjoint or merely touch.
    function automatic longint overlap_length(input longint a, input longint la,
                                              input longint b, input longint lb);
        longint hi;
        longint lo;
        hi = (a + la > b + lb) ? a + la : b + lb;
        lo = (a < b) ? a : b;
        return la + lb - (hi - lo);
    endfunction

    // The ratio is floor(inter * 2^FRACTION_BITS / divisor). The intersection
    // never exceeds the divisor, so the result stays at or below 1.0. The
    // 64-bit intermediate values cannot overflow at these widths.
    function automatic t_res predict_overlap(input t_req req);
        longint iw;
        longint ih;
        longint inter;
        longint area_first;
        longint area_second;
        longint divisor;
        t_res   res;
        res = '0;
        iw = overlap_length(longint'(req.first_x), longint'(req.first_width),
                            longint'(req.second_x), longint'(req.second_width));
        ih = overlap_length(longint'(req.first_y), longint'(req.first_height),
                            longint'(req.second_y), longint'(req.second_height));
        if (iw > 0 && ih > 0) begin
            inter       = iw * ih;
            area_first  = longint'(req.first_width) * longint'(req.first_height);
            area_second = longint'(req.second_width) * longint'(req.second_height);
            if (req.command == CMD_UNION) begin
                divisor = area_first + area_second - inter;
            end else begin
                divisor = (area_first < area_second) ? area_first : area_second;
            end
            // The divisor is guarded although it cannot be zero once the boxes overlap.
            if (divisor != 0) begin
                res.ratio = QUO_BITS'((inter <<< FRACTION_BITS) / divisor);
            end
            res.intersects = 1'b1;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Drives one request after a random gap and holds it until it is taken.
    // When the gap is zero, valid stays high across back-to-back requests.
    // The expectation is queued in the same time step as the acceptance, so
    // the final drain cannot miss it.
    task automatic send_request(input t_req req);
        int gap;
        gap = calm_requests ? 0 : $urandom_range(0, 8);
        if (gap != 0) begin
            i_req_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_req_valid <= 1'b1;
        i_req       <= req;
        do @(posedge i_clk); while (!o_req_ready);
        expected_ratios.push_back(predict_overlap(req));
    endtask

    task automatic send_boxes(input t_cmd cmd,
                              input int x1, input int y1, input int w1, input int h1,
                              input int x2, input int y2, input int w2, input int h2);
        t_req req;
        req.command       = cmd;
        req.first_x       = COORD_BITS'(x1);
        req.first_y       = COORD_BITS'(y1);
        req.first_width   = COORD_BITS'(w1);
        req.first_height  = COORD_BITS'(h1);
        req.second_x      = COORD_BITS'(x2);
        req.second_y      = COORD_BITS'(y2);
        req.second_width  = COORD_BITS'(w2);
        req.second_height = COORD_BITS'(h2);
        send_request(req);
    endtask

    // ------------------------------------------------------------------
    // Result side: the receiver stalls for a random number of cycles before
    // each result. The checker compares every accepted result with the
    // oldest prediction.
    // ------------------------------------------------------------------

    initial begin
        int stall;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = calm_results ? 0 : $urandom_range(0, 8);
            if (stall != 0) begin
                i_res_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_res_ready <= 1'b1;
            do @(posedge i_clk); while (!o_res_valid);
        end
    end

    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && o_res_valid && i_res_ready) begin
            if (expected_ratios.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTED) begin
                    $display("unexpected result: ratio %h intersects %b",
                             o_res.ratio, o_res.intersects);
                end
            end else begin
                want = expected_ratios.pop_front();
                if (o_res.ratio !== want.ratio || o_res.intersects !== want.intersects) begin
                    error_count++;
                    if (error_count <= MAX_REPORTED) begin
                        $display("mismatch: expected ratio %h intersects %b, got ratio %h intersects %b",
                                 want.ratio, want.intersects, o_res.ratio, o_res.intersects);
                    end
                end
            end
        end
    end

    // Watchdog. A hung handshake ends the run here.
    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("** box_overlap_ratio: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Identical boxes give exactly 1.0 under either measure, including the
    // largest box that the fields allow.
    task automatic test_identical_boxes();
        send_boxes(CMD_UNION,   10, 20, 30, 40, 10, 20, 30, 40);
        send_boxes(CMD_SMALLER, 10, 20, 30, 40, 10, 20, 30, 40);
        send_boxes(CMD_UNION,   COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                                COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
        send_boxes(CMD_SMALLER, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX,
                                COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
    endtask

    // Boxes that only share an edge, or lie far apart, do not intersect.
    task automatic test_touching_and_disjoint();
        send_boxes(CMD_UNION,   0, 0, 10, 10, 10, 0, 10, 10);
        send_boxes(CMD_SMALLER, 0, 0, 10, 10, 0, 10, 10, 10);
        send_boxes(CMD_UNION,   0, 0, 5, 5, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
        send_boxes(CMD_SMALLER, 0, 0, COORD_MAX, COORD_MAX, COORD_MAX, 0, COORD_MAX, COORD_MAX);
    endtask

    // A box of zero width or height never intersects, even when it lies inside the other box.
    task automatic test_zero_size();
        send_boxes(CMD_UNION,   5, 5, 0, 3, 0, 0, 20, 20);
        send_boxes(CMD_SMALLER, 0, 0, 20, 20, 5, 5, 3, 0);
        send_boxes(CMD_UNION,   0, 0, 0, 0, 0, 0, 0, 0);
        send_boxes(CMD_SMALLER, 0, 0, 0, 0, 0, 0, 0, 0);
    endtask

    // A box inside a larger one scores 1.0 over the smaller area. Over the
    // union, a 1x1 box inside the largest box truncates to zero but still
    // counts as an intersection.
    task automatic test_containment();
        send_boxes(CMD_SMALLER, 100, 100, 10, 20, 50, 50, 200, 300);
        send_boxes(CMD_UNION,   100, 100, 10, 20, 50, 50, 200, 300);
        send_boxes(CMD_UNION,   7, 9, 1, 1, 0, 0, COORD_MAX, COORD_MAX);
        send_boxes(CMD_SMALLER, 7, 9, 1, 1, 0, 0, COORD_MAX, COORD_MAX);
    endtask

    // Partial overlaps: a small one with a non-terminating quotient, and a
    // one-pixel overlap whose right and bottom edges go past the coordinate range.
    task automatic test_partial_overlap();
        send_boxes(CMD_UNION,   0, 0, 4, 4, 2, 2, 4, 4);
        send_boxes(CMD_SMALLER, 0, 0, 4, 4, 2, 2, 4, 4);
        send_boxes(CMD_UNION,   COORD_MAX - 1, COORD_MAX - 1, COORD_MAX, COORD_MAX,
                                0, 0, COORD_MAX, COORD_MAX);
        send_boxes(CMD_SMALLER, COORD_MAX - 1, COORD_MAX - 1, COORD_MAX, COORD_MAX,
                                0, 0, COORD_MAX, COORD_MAX);
    endtask

    // Sizes are drawn mostly small, so that overlaps are common, and now and
    // then over the whole range.
    function automatic int random_size();
        case ($urandom_range(0, 3))
            0:       return $urandom_range(0, 8);
            1:       return $urandom_range(0, 255);
            2:       return $urandom_range(0, 4095);
            default: return $urandom_range(0, COORD_MAX);
        endcase
    endfunction

    // Places the second span so that it overlaps or touches the first span
    // [a, a + la). Clamping at the range limits never pushes it clear.
    function automatic int nearby_coord(input int a, input int la, input int lb);
        int pos;
        pos = a + int'($urandom_range(0, la + lb)) - lb;
        if (pos < 0) pos = 0;
        if (pos > COORD_MAX) pos = COORD_MAX;
        return pos;
    endfunction

    // Most pairs are built to overlap or touch. About one in five has every
    // field drawn over its full range, so that every bit toggles.
    function automatic t_req random_box_pair();
        t_req req;
        int   x1;
        int   y1;
        int   w1;
        int   h1;
        int   w2;
        int   h2;
        req.command = t_cmd'($urandom_range(0, 1));
        if ($urandom_range(0, 4) == 0) begin
            req.first_x       = COORD_BITS'($urandom_range(0, COORD_MAX));
            req.first_y       = COORD_BITS'($urandom_range(0, COORD_MAX));
            req.first_width   = COORD_BITS'($urandom_range(0, COORD_MAX));
            req.first_height  = COORD_BITS'($urandom_range(0, COORD_MAX));
            req.second_x      = COORD_BITS'($urandom_range(0, COORD_MAX));
            req.second_y      = COORD_BITS'($urandom_range(0, COORD_MAX));
            req.second_width  = COORD_BITS'($urandom_range(0, COORD_MAX));
            req.second_height = COORD_BITS'($urandom_range(0, COORD_MAX));
        end else begin
            x1 = $urandom_range(0, COORD_MAX);
            y1 = $urandom_range(0, COORD_MAX);
            w1 = random_size();
            h1 = random_size();
            w2 = random_size();
            h2 = random_size();
            req.first_x       = COORD_BITS'(x1);
            req.first_y       = COORD_BITS'(y1);
            req.first_width   = COORD_BITS'(w1);
            req.first_height  = COORD_BITS'(h1);
            req.second_x      = COORD_BITS'(nearby_coord(x1, w1, w2));
            req.second_y      = COORD_BITS'(nearby_coord(y1, h1, h2));
            req.second_width  = COORD_BITS'(w2);
            req.second_height = COORD_BITS'(h2);
        end
        return req;
    endfunction

    // Random pairs in bursts of 50. Before each burst, either side may be
    // made to run without gaps, so that back-to-back streaming and full-pipeline
    // back-pressure both occur.
    task automatic test_random_pairs();
        for (int n = 0; n < RANDOM_PAIRS; n++) begin
            if (n % 50 == 0) begin
                calm_requests = ($urandom_range(0, 3) == 0);
                calm_results  = ($urandom_range(0, 3) == 0);
            end
            send_request(random_box_pair());
        end
        calm_requests = 1'b0;
        calm_results  = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        i_rst_n       <= 1'b0;
        i_req_valid   <= 1'b0;
        i_req         <= '0;
        i_res_ready   <= 1'b0;
        error_count   = 0;
        cycle_count   = 0;
        calm_requests = 1'b0;
        calm_results  = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_identical_boxes();
        test_touching_and_disjoint();
        test_zero_size();
        test_containment();
        test_partial_overlap();
        test_random_pairs();

        // The last request has just been taken, so valid drops in this step.
        i_req_valid <= 1'b0;
        while (expected_ratios.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0 && expected_ratios.size() == 0) begin
            $display("** box_overlap_ratio: PASSED **");
        end else begin
            $display("** box_overlap_ratio: FAILED **");
        end
        $finish;
    end

endmodule
